>>> rtl/psc_pkg.sv
// Package for the palindromic substring counter.
// Holds shared widths, defaults and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package psc_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int COUNT_W     = 23;
	localparam int CHAR_W      = 8;

	typedef struct packed {
		logic store;
		logic clr;
		logic init_even;
		logic init_odd;
		logic step;
		logic next_c;
		logic finish;
	} psc_cmd_t;

	typedef struct packed {
		logic in_bounds;
		logic match;
		logic centre_done;
	} psc_stat_t;

endpackage

`default_nettype wire

>>> rtl/psc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module psc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

>>> rtl/psc_ctrl.sv
// Controller for the palindromic substring counter.
// Sequences byte stores and the centre expansion walk; depends on psc_pkg.
`default_nettype none

module psc_ctrl
	import psc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      end_of_line,
	input  wire psc_stat_t stat,
	output logic           busy,
	output psc_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CENT  = 3'd1;
	localparam logic [2:0] S_CHK_E = 3'd2;
	localparam logic [2:0] S_CMP_E = 3'd3;
	localparam logic [2:0] S_CHK_O = 3'd4;
	localparam logic [2:0] S_CMP_O = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (end_of_line) begin
						cmd.clr = 1'b1;
						state_d = S_CENT;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			S_CENT: begin
				if (stat.centre_done) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.init_even = 1'b1;
					state_d       = S_CHK_E;
				end
			end
			S_CHK_E: begin
				if (stat.in_bounds) begin
					state_d = S_CMP_E;
				end else begin
					cmd.init_odd = 1'b1;
					state_d      = S_CHK_O;
				end
			end
			S_CMP_E: begin
				if (stat.match) begin
					cmd.step = 1'b1;
					state_d  = S_CHK_E;
				end else begin
					cmd.init_odd = 1'b1;
					state_d      = S_CHK_O;
				end
			end
			S_CHK_O: begin
				if (stat.in_bounds) begin
					state_d = S_CMP_O;
				end else begin
					cmd.next_c = 1'b1;
					state_d    = S_CENT;
				end
			end
			S_CMP_O: begin
				if (stat.match) begin
					cmd.step = 1'b1;
					state_d  = S_CHK_O;
				end else begin
					cmd.next_c = 1'b1;
					state_d    = S_CENT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/psc_dp.sv
// Datapath for the palindromic substring counter.
// Line store, position registers, running total and result registers;
// depends on psc_pkg and psc_ram.
`default_nettype none

module psc_dp
	import psc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CHAR_W-1:0] ch,
	input  wire psc_cmd_t          cmd,
	output psc_stat_t              stat,
	output logic                   done,
	output logic [COUNT_W-1:0]     pal_count,
	output logic                   overflowed
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);

	logic [LW-1:0]      len_q;
	logic [LW-1:0]      c_q;
	logic [LW:0]        left_q;
	logic [LW-1:0]      right_q;
	logic [COUNT_W-1:0] total_q;
	logic               drop_q;
	logic               full;
	logic               we;
	logic [CHAR_W-1:0]  rdata_l;
	logic [CHAR_W-1:0]  rdata_r;

	assign full = (len_q == LW'(MAX_LEN));
	assign we   = cmd.store && !full;

	psc_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_LEN)
	) u_line (
		.clk    (clk),
		.we     (we),
		.waddr  (len_q[AW-1:0]),
		.wdata  (ch),
		.raddr_a(left_q[AW-1:0]),
		.raddr_b(right_q[AW-1:0]),
		.rdata_a(rdata_l),
		.rdata_b(rdata_r)
	);

	assign stat.in_bounds   = !left_q[LW] && (right_q < len_q);
	assign stat.match       = (rdata_l == rdata_r);
	assign stat.centre_done = (c_q >= len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			c_q        <= '0;
			left_q     <= '0;
			right_q    <= '0;
			total_q    <= '0;
			drop_q     <= 1'b0;
			done       <= 1'b0;
			pal_count  <= '0;
			overflowed <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cmd.store) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					len_q <= len_q + LW'(1);
				end
			end
			if (cmd.clr) begin
				total_q <= '0;
				c_q     <= LW'(1);
			end
			if (cmd.init_even) begin
				left_q  <= {1'b0, c_q} - (LW+1)'(1);
				right_q <= c_q;
			end
			if (cmd.init_odd) begin
				left_q  <= {1'b0, c_q} - (LW+1)'(2);
				right_q <= c_q;
			end
			if (cmd.step) begin
				if (total_q != '1) begin
					total_q <= total_q + COUNT_W'(1);
				end
				left_q  <= left_q - (LW+1)'(1);
				right_q <= right_q + LW'(1);
			end
			if (cmd.next_c) begin
				c_q <= c_q + LW'(1);
			end
			if (cmd.finish) begin
				pal_count  <= total_q;
				overflowed <= drop_q;
				done       <= 1'b1;
				len_q      <= '0;
				drop_q     <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/palindromic_substring_counter.sv
// Byte beats: taken one per cycle while busy is low.
// End-of-line beat: busy stays high while the count walks every centre, expanding it while
// the bytes match; each compare waits on a registered RAM read.
// done pulses for one cycle when busy falls; the receiver cannot stall.
// Reset (arst_n low) clears the line length, drop flag and controller; the line store is
// not cleared.
`default_nettype none

module palindromic_substring_counter
	import psc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CHAR_W-1:0] ch,
	input  wire logic              end_of_line,
	output logic                   busy,
	output logic                   done,
	output logic [COUNT_W-1:0]     pal_count,
	output logic                   overflowed
);

	psc_cmd_t  cmd;
	psc_stat_t stat;

	psc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.end_of_line(end_of_line),
		.stat       (stat),
		.busy       (busy),
		.cmd        (cmd)
	);

	psc_dp #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch        (ch),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.pal_count (pal_count),
		.overflowed(overflowed)
	);

endmodule

`default_nettype wire

>>> rtl/psc_checker.sv
// Port-level checker for the palindromic substring counter, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module psc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic end_of_line,
	input wire logic busy,
	input wire logic done
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_eol_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && end_of_line) |=> busy)
		else $error("end-of-line beat did not start a count");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done without a finished count");

	a_byte_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !end_of_line) |=> !done)
		else $error("byte beat produced a result");

endmodule

bind palindromic_substring_counter psc_checker u_psc_checker (.*);

`default_nettype wire

>>> bench/tb_palindromic_substring_counter.sv
`timescale 1ns / 100ps
// Testbench for palindromic_substring_counter: directed table and random lines.
// Checks each count and overflow flag vs table values or a centre-expansion predictor.
// Depends on psc_pkg and the palindromic_substring_counter RTL.

module tb_palindromic_substring_counter;
	import psc_pkg::*;

	localparam int LINE_CAP    = MAX_LEN_DEF;
	localparam int STALL_LIMIT = 200000;
	localparam int RAND_BEATS  = 525;

	typedef struct {
		logic [CHAR_W-1:0]  ch;
		logic               eol;
		bit                 fixed;
		logic [COUNT_W-1:0] fixed_count;
		logic               fixed_ovf;
		bit                 steady;
	} beat_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} line_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [CHAR_W-1:0] ch = '0;
	logic              end_of_line = 1'b0;
	logic              busy;
	logic              done;
	logic [COUNT_W-1:0] pal_count;
	logic              overflowed;

	beat_t        stim_q[$];
	line_result_t line_results_q[$];
	beat_t        cur_beat;

	logic [CHAR_W-1:0] line_mem [0:LINE_CAP-1];
	int  line_len = 0;
	bit  line_dropped = 0;

	int beats_total = 0;
	int beats_taken = 0;
	int lines_checked = 0;
	int err_cnt = 0;
	int quiet_cycles = 0;
	bit timed_out = 0;

	// ch, eol, fixed, count, ovf, steady
	beat_t dir_table [0:23] = '{
		'{8'hFF, 1'b1, 1'b1, 23'd0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 23'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h5C, 1'b1, 1'b1, 23'd0, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 23'd1, 1'b0, 1'b0},
		'{8'hAA, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hAA, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hAA, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h33, 1'b1, 1'b1, 23'd3, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h02, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h03, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hC3, 1'b1, 1'b1, 23'd0, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hA5, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'hA5, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h7E, 1'b1, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h7F, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 23'd0, 1'b0, 1'b0},
		'{8'h81, 1'b1, 1'b0, 23'd0, 1'b0, 1'b0}
	};

	palindromic_substring_counter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.ch         (ch),
		.end_of_line(end_of_line),
		.busy       (busy),
		.done       (done),
		.pal_count  (pal_count),
		.overflowed (overflowed)
	);

	always #5 clk = ~clk;

	function automatic logic [COUNT_W-1:0] palindromes_in_line();
		logic [COUNT_W-1:0] total;
		int c, k, lo, hi;
		total = '0;
		for (c = 1; c < line_len; c++) begin
			for (k = 0; k < 2; k++) begin
				lo = c - 1 - k;
				hi = c;
				while (lo >= 0 && hi < line_len && line_mem[lo] == line_mem[hi]) begin
					if (total != {COUNT_W{1'b1}})
						total++;
					lo--;
					hi++;
				end
			end
		end
		return total;
	endfunction

	function automatic void absorb_beat(beat_t b);
		line_result_t r;
		if (!b.eol) begin
			if (line_len < LINE_CAP) begin
				line_mem[line_len] = b.ch;
				line_len++;
			end else begin
				line_dropped = 1;
			end
		end else begin
			r.count = b.fixed ? b.fixed_count : palindromes_in_line();
			r.ovf   = b.fixed ? b.fixed_ovf : line_dropped;
			line_results_q.push_back(r);
			line_len = 0;
			line_dropped = 0;
		end
	endfunction

	task automatic add_beat(logic [CHAR_W-1:0] c, logic e, bit steady);
		beat_t b;
		b.ch = c;
		b.eol = e;
		b.fixed = 0;
		b.fixed_count = '0;
		b.fixed_ovf = 1'b0;
		b.steady = steady;
		stim_q.push_back(b);
	endtask

	task automatic queue_random_line(bit steady, output int n_beats);
		logic [CHAR_W-1:0] half [0:15];
		logic [CHAR_W-1:0] sym_a, sym_b, mid;
		int style, n, i, h;
		bit odd;
		style = $urandom_range(9);
		sym_a = CHAR_W'($urandom);
		sym_b = CHAR_W'($urandom);
		n = 0;
		case (style)
			0: begin
				n = 0;
			end
			1, 2, 3, 4, 5: begin
				n = $urandom_range(20, 1);
				for (i = 0; i < n; i++)
					add_beat($urandom_range(1) ? sym_a : sym_b, 1'b0, steady);
			end
			6, 7: begin
				n = $urandom_range(20, 1);
				for (i = 0; i < n; i++)
					add_beat(CHAR_W'($urandom), 1'b0, steady);
			end
			8: begin
				h = $urandom_range(12, 1);
				odd = 1'($urandom_range(1));
				mid = CHAR_W'($urandom);
				for (i = 0; i < h; i++)
					half[i] = $urandom_range(2) == 0 ? CHAR_W'($urandom) :
						($urandom_range(1) ? sym_a : sym_b);
				for (i = 0; i < h; i++)
					add_beat(half[i], 1'b0, steady);
				if (odd)
					add_beat(mid, 1'b0, steady);
				for (i = h - 1; i >= 0; i--)
					add_beat(half[i], 1'b0, steady);
				n = 2 * h + odd;
			end
			default: begin
				n = $urandom_range(64, 2);
				for (i = 0; i < n; i++)
					add_beat(sym_a, 1'b0, steady);
			end
		endcase
		add_beat(CHAR_W'($urandom), 1'b1, steady);
		n_beats = n + 1;
	endtask

	always @(posedge clk) begin : beat_flow
		line_result_t want;
		bit taken;
		bit may_idle;
		taken = 0;
		if (done === 1'b1) begin
			if (line_results_q.size() == 0) begin
				$display("%0t: unexpected result: count %0d overflowed %0b",
					$time, pal_count, overflowed);
				err_cnt++;
			end else begin
				want = line_results_q.pop_front();
				if (pal_count !== want.count) begin
					$display("%0t: pal_count mismatch: expected %0d, actual %0d",
						$time, want.count, pal_count);
					err_cnt++;
				end
				if (overflowed !== want.ovf) begin
					$display("%0t: overflowed mismatch: expected %0b, actual %0b",
						$time, want.ovf, overflowed);
					err_cnt++;
				end
				lines_checked++;
			end
		end
		if (arst_n) begin
			if (start && !busy) begin
				taken = 1;
				beats_taken++;
				absorb_beat(cur_beat);
			end
			if (taken || !start) begin
				may_idle = stim_q.size() > 0 && !stim_q[0].steady;
				if (stim_q.size() > 0 && !(may_idle && $urandom_range(99) < 12)) begin
					cur_beat = stim_q.pop_front();
					start <= 1'b1;
					ch <= cur_beat.ch;
					end_of_line <= cur_beat.eol;
				end else begin
					start <= 1'b0;
					ch <= CHAR_W'($urandom);
					end_of_line <= 1'($urandom);
				end
			end
		end
		quiet_cycles <= (taken || done === 1'b1) ? 0 : quiet_cycles + 1;
	end

	initial begin : main
		int i, n, rand_beats;
		for (i = 0; i < 24; i++)
			stim_q.push_back(dir_table[i]);

		rand_beats = 0;
		while (rand_beats < RAND_BEATS) begin
			queue_random_line(rand_beats >= 150 && rand_beats < 300, n);
			rand_beats += n;
		end
		beats_total = stim_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (beats_taken < beats_total || line_results_q.size() > 0)) begin
			@(posedge clk);
			if (quiet_cycles >= STALL_LIMIT)
				timed_out = 1;
		end
		if (timed_out)
			$display("%0t: timeout: %0d of %0d beats taken, %0d results pending",
				$time, beats_taken, beats_total, line_results_q.size());
		else
			repeat (64) @(posedge clk);

		$display("Ran %0d beats and checked %0d lines: empty, short and directed lines,",
			beats_taken, lines_checked);
		$display("then random lines of repeats, mirrors and noise with and without idling.");
		if (err_cnt == 0 && !timed_out) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
